[rtl/core/gcbt_pkg.sv]
// Package for the grid cell binning table.
// Holds function, status, register and phase codes and the shared structs.
package gcbt_pkg;
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_MOVE   = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;
    localparam logic [1:0] ST_STALE   = 2'd3;

    localparam logic [1:0] REG_CELL_SIZE    = 2'd0;
    localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [1:0] REG_ROW_COUNT    = 2'd2;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_DIV  = 3'd1;
    localparam logic [2:0] PH_P1   = 3'd2;
    localparam logic [2:0] PH_P2   = 3'd3;
    localparam logic [2:0] PH_P3   = 3'd4;
    localparam logic [2:0] PH_P4   = 3'd5;
    localparam logic [2:0] PH_OUT  = 3'd6;

    typedef struct packed {
        logic [7:0] cell_now;
        logic [3:0] slot_now;
        logic [5:0] member_id;
        logic [4:0] fill;
        logic       moved;
        logic [1:0] status;
    } result_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  particle_id;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [7:0]  read_cell;
        logic [3:0]  read_slot;
    } item_t;

    typedef struct packed {
        logic       load;
        logic [2:0] phase;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic clearing;
    } dp_stat_t;
endpackage

[rtl/core/gcbt_if.sv]
// Valid/ready channel interfaces for the grid cell binning table.
// Depends on gcbt_pkg.
interface gcbt_item_if;
    gcbt_pkg::item_t data;
    logic valid;
    logic ready;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gcbt_result_if;
    gcbt_pkg::result_t data;
    logic valid;
    logic ready;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gcbt_cfg_if;
    logic [1:0]  index;
    logic [11:0] wdata;
    logic        valid;
    logic        ready;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

[rtl/core/gcbt_ctrl.sv]
// Controller state machine for the grid cell binning table.
// Sequences load, divide, memory and output phases; depends on gcbt_pkg.
module gcbt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output gcbt_pkg::dp_cmd_t  cmd,
    input  gcbt_pkg::dp_stat_t stat
);
    import gcbt_pkg::*;

    localparam logic [2:0] S_IDLE = PH_IDLE;
    localparam logic [2:0] S_DIV  = PH_DIV;
    localparam logic [2:0] S_P1   = PH_P1;
    localparam logic [2:0] S_P2   = PH_P2;
    localparam logic [2:0] S_P3   = PH_P3;
    localparam logic [2:0] S_P4   = PH_P4;
    localparam logic [2:0] S_OUT  = PH_OUT;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid && in_ready) state_next = S_DIV;
            S_DIV:  if (stat.div_done) state_next = S_P1;
            S_P1:   state_next = S_P2;
            S_P2:   state_next = S_P3;
            S_P3:   state_next = S_P4;
            S_P4:   state_next = S_OUT;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready      = (state_reg == S_IDLE) && !stat.clearing;
    assign out_valid     = (state_reg == S_OUT);
    assign cmd.load      = in_valid && in_ready;
    assign cmd.phase     = state_reg;
endmodule

[rtl/core/gcbt_dp.sv]
// Datapath for the grid cell binning table: divider, cell index, stores.
// Depends on gcbt_pkg; driven by gcbt_ctrl.
module gcbt_dp
#(
    parameter int MAX_PARTICLES = 64,
    parameter int MAX_CELLS     = 256,
    parameter int CELL_CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  gcbt_pkg::item_t    item,
    input  logic [11:0]        cell_size,
    input  logic [8:0]         column_count,
    input  logic [8:0]         row_count,
    input  gcbt_pkg::dp_cmd_t  cmd,
    output gcbt_pkg::dp_stat_t stat,
    output gcbt_pkg::result_t  result
);
    import gcbt_pkg::*;

    localparam int PW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int SW = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
    localparam int FW = $clog2(CELL_CAPACITY + 1);
    localparam int AW = CW + SW;
    localparam int NW = 18;

    logic [PW-1:0] slot_mem [2**AW];
    logic [SW-1:0] pslot_mem [MAX_PARTICLES];
    logic [CW-1:0] pcell_mem [MAX_PARTICLES];
    logic [FW-1:0] fill_mem [MAX_CELLS];

    item_t         item_reg;
    logic [PW-1:0] pid;
    logic [PW-1:0] pid_map [64];
    logic [11:0]   divisor;

    // restoring dividers for x and y, one bit a cycle
    logic [11:0] qx_reg, qy_reg, rx_reg, ry_reg;
    logic [3:0]  cnt_reg;
    logic [12:0] trx, try_;

    // particle id wraps modulo MAX_PARTICLES
    for (genvar g = 0; g < 64; g++)
    begin : g_pid_map
        assign pid_map[g] = PW'(g % MAX_PARTICLES);
    end

    assign pid     = pid_map[item_reg.particle_id];
    assign divisor = (cell_size == 12'd0) ? 12'd1 : cell_size;
    assign trx     = {rx_reg, qx_reg[11]} - {1'b0, divisor};
    assign try_    = {ry_reg, qy_reg[11]} - {1'b0, divisor};
    assign stat.div_done = (cmd.phase == PH_DIV) && (cnt_reg == 4'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            qx_reg   <= item.pos_x;
            qy_reg   <= item.pos_y;
            rx_reg   <= '0;
            ry_reg   <= '0;
            cnt_reg  <= 4'd12;
        end
        else if (cmd.phase == PH_DIV && cnt_reg != 4'd0)
        begin
            cnt_reg <= cnt_reg - 4'd1;
            if (!trx[12])
            begin
                rx_reg <= trx[11:0];
                qx_reg <= {qx_reg[10:0], 1'b1};
            end
            else
            begin
                rx_reg <= {rx_reg[10:0], qx_reg[11]};
                qx_reg <= {qx_reg[10:0], 1'b0};
            end
            if (!try_[12])
            begin
                ry_reg <= try_[11:0];
                qy_reg <= {qy_reg[10:0], 1'b1};
            end
            else
            begin
                ry_reg <= {ry_reg[10:0], qy_reg[11]};
                qy_reg <= {qy_reg[10:0], 1'b0};
            end
        end
    end

    // fill count clearing pass after reset, one cell a cycle
    logic          clr_busy_reg;
    logic [CW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + CW'(1);
            if (clr_addr_reg == CW'(MAX_CELLS - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    assign stat.clearing = clr_busy_reg;

    // phase 1: cell index, particle records
    logic          inside_reg;
    logic [CW-1:0] old_reg, new_reg;
    logic [SW-1:0] s_reg;
    logic [NW-1:0] idx_full;

    assign idx_full = NW'(qy_reg) * NW'(column_count) + NW'(qx_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.phase == PH_P1)
        begin
            inside_reg <= (qx_reg < 12'(column_count)) && (qy_reg < 12'(row_count))
                          && (idx_full < NW'(MAX_CELLS));
            new_reg    <= CW'(idx_full);
            old_reg    <= pcell_mem[pid];
            s_reg      <= pslot_mem[pid];
        end
    end

    // phase 2: fill counts
    logic [FW-1:0] fo_reg, fn_reg;
    logic [PW-1:0] last_reg, rd_reg;
    logic [CW-1:0] rcell;
    logic [SW-1:0] rslot;
    logic          do_ins, do_move, same;

    assign rcell   = CW'(item_reg.read_cell);
    assign rslot   = SW'(item_reg.read_slot);

    always_ff @(posedge clk)
    begin
        if (cmd.phase == PH_P2)
        begin
            fo_reg <= (item_reg.func == FUNC_READ) ? fill_mem[rcell] : fill_mem[old_reg];
            fn_reg <= fill_mem[new_reg];
        end
    end

    // phase 3: slot reads
    always_ff @(posedge clk)
    begin
        if (cmd.phase == PH_P3)
        begin
            last_reg <= slot_mem[{old_reg, SW'(fo_reg - FW'(1))}];
            rd_reg   <= slot_mem[{rcell, rslot}];
        end
    end

    assign same    = (new_reg == old_reg);
    assign do_ins  = (item_reg.func == FUNC_INSERT) && inside_reg
                     && (fn_reg < FW'(CELL_CAPACITY));
    assign do_move = (item_reg.func == FUNC_MOVE) && inside_reg && !same
                     && (fn_reg < FW'(CELL_CAPACITY)) && (FW'(s_reg) < fo_reg);

    // phase 4: updates and result
    always_ff @(posedge clk)
    begin
        if (cmd.phase == PH_P4)
        begin
            if (do_ins || do_move)
            begin
                slot_mem[{new_reg, SW'(fn_reg)}] <= pid;
                pslot_mem[pid] <= SW'(fn_reg);
                pcell_mem[pid] <= new_reg;
            end
            if (do_move)
            begin
                slot_mem[{old_reg, s_reg}] <= last_reg;
                if (last_reg != pid)
                    pslot_mem[last_reg] <= s_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            fill_mem[clr_addr_reg] <= '0;
        else if (cmd.phase == PH_P4)
        begin
            if (do_ins || do_move)
                fill_mem[new_reg] <= fn_reg + FW'(1);
            if (do_move)
                fill_mem[old_reg] <= fo_reg - FW'(1);
        end
    end

    result_t res_next, result_reg;

    always_comb
    begin
        res_next = '0;
        case (item_reg.func)
            FUNC_INSERT:
            begin
                if (!inside_reg)
                    res_next.status = ST_OUTSIDE;
                else if (!do_ins)
                begin
                    res_next.cell_now = 8'(new_reg);
                    res_next.fill     = 5'(fn_reg);
                    res_next.status   = ST_FULL;
                end
                else
                begin
                    res_next.cell_now = 8'(new_reg);
                    res_next.slot_now = 4'(fn_reg);
                    res_next.fill     = 5'(fn_reg + FW'(1));
                end
            end
            FUNC_MOVE:
            begin
                res_next.cell_now = 8'(old_reg);
                res_next.slot_now = 4'(s_reg);
                res_next.fill     = 5'(fo_reg);
                if (!inside_reg)
                    res_next.status = ST_OUTSIDE;
                else if (same)
                    res_next.status = ST_OK;
                else if (fn_reg >= FW'(CELL_CAPACITY))
                    res_next.status = ST_FULL;
                else if (!do_move)
                    res_next.status = ST_STALE;
                else
                begin
                    res_next.cell_now = 8'(new_reg);
                    res_next.slot_now = 4'(fn_reg);
                    res_next.fill     = 5'(fn_reg + FW'(1));
                    res_next.moved    = 1'b1;
                end
            end
            FUNC_READ:
            begin
                res_next.cell_now = item_reg.read_cell;
                res_next.slot_now = item_reg.read_slot;
                if (32'(item_reg.read_cell) >= 32'(MAX_CELLS))
                    res_next.status = ST_OUTSIDE;
                else
                begin
                    res_next.fill = 5'(fo_reg);
                    if (5'(item_reg.read_slot) >= 5'(fo_reg))
                        res_next.status = ST_STALE;
                    else
                        res_next.member_id = 6'(rd_reg);
                end
            end
            default: res_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.phase == PH_P4)
            result_reg <= res_next;
    end

    assign result = result_reg;
endmodule

[rtl/core/grid_cell_binning_table_top.sv]
// Top level of the grid cell binning table.
// Depends on gcbt_pkg, gcbt_if, gcbt_ctrl and gcbt_dp.
//
//  channel  | dir | payload
//  ---------+-----+------------------------------------------
//  item     | in  | func, particle_id, pos_x, pos_y, read_cell, read_slot
//  result   | out | cell_now, slot_now, member_id, fill, moved, status
//  cfg      | in  | index, wdata
//
// A transaction with no stall runs through the accepting idle state, the
// bit-serial position divide (12 steps and a done check), four memory
// phases and the output state. One item at a time.
// After reset the fill counts are cleared one per cycle over all MAX_CELLS
// cells (256 by default); item.ready stays low until that pass ends.
// A stalled result holds the block until taken.
module grid_cell_binning_table_top
#(
    parameter int MAX_PARTICLES = 64,
    parameter int MAX_CELLS     = 256,
    parameter int CELL_CAPACITY = 16
)
(
    input  logic   clk,
    input  logic   rst_n,
    gcbt_item_if.sink     item,
    gcbt_result_if.source result,
    gcbt_cfg_if.sink      cfg
);
    import gcbt_pkg::*;

    logic [11:0] cell_size_reg;
    logic [8:0]  column_count_reg, row_count_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg    <= 12'd16;
            column_count_reg <= 9'd16;
            row_count_reg    <= 9'd16;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_CELL_SIZE:    cell_size_reg    <= cfg.wdata;
                REG_COLUMN_COUNT: column_count_reg <= cfg.wdata[8:0];
                REG_ROW_COUNT:    row_count_reg    <= cfg.wdata[8:0];
                default: ;
            endcase
        end
    end

    gcbt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    gcbt_dp #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .MAX_CELLS     (MAX_CELLS),
        .CELL_CAPACITY (CELL_CAPACITY)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item.data),
        .cell_size    (cell_size_reg),
        .column_count (column_count_reg),
        .row_count    (row_count_reg),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result.data)
    );
endmodule

[sim/tb_grid_cell_binning_table_top.sv]
// Testbench for grid_cell_binning_table_top: directed and random insert, move and
// read transactions across several grid settings, each result checked against a
// behavioral model of the cell table. Depends on gcbt_pkg and gcbt_if.
module tb_grid_cell_binning_table_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gcbt_pkg::*;

    localparam int NPART = 64;
    localparam int NCELL = 256;
    localparam int CAP   = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gcbt_item_if   item();
    gcbt_result_if result();
    gcbt_cfg_if    cfg();

    grid_cell_binning_table_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    always #4 clk = ~clk;

    // model state
    logic [11:0] m_cell_size = 12'd16;
    logic [8:0]  m_cols = 9'd16;
    logic [8:0]  m_rows = 9'd16;
    logic [5:0]  m_slots [0:NCELL*CAP-1];
    int          m_fill [0:NCELL-1];
    int          m_pslot [0:NPART-1];
    int          m_pcell [0:NPART-1];
    bit          m_known [0:NPART-1];

    item_t   pending_items [$];
    result_t expected_bins [$];
    int      errors = 0;
    int      results_seen = 0;
    int      counts_by_status [0:3];
    bit      idle_on = 1'b1;

    function automatic bit locate_cell(input logic [11:0] x, input logic [11:0] y,
                                       output int cidx);
        int d;
        int col;
        int row;
        d = (m_cell_size == 0) ? 1 : int'(m_cell_size);
        col = int'(x) / d;
        row = int'(y) / d;
        cidx = 0;
        if (col >= int'(m_cols) || row >= int'(m_rows))
            return 1'b0;
        cidx = row * int'(m_cols) + col;
        return cidx < NCELL;
    endfunction

    function automatic result_t make_res(int c, int s, int m, int f, bit mv, logic [1:0] st);
        result_t r;
        r.cell_now = c[7:0];
        r.slot_now = s[3:0];
        r.member_id = m[5:0];
        r.fill = f[4:0];
        r.moved = mv;
        r.status = st;
        return r;
    endfunction

    function automatic void add_to_cell(int cidx, int pid);
        int s;
        s = m_fill[cidx];
        m_slots[cidx*CAP + s] = pid[5:0];
        m_pslot[pid] = s;
        m_pcell[pid] = cidx;
        m_fill[cidx] = s + 1;
        m_known[pid] = 1'b1;
    endfunction

    function automatic result_t bin_step(item_t it);
        int pid;
        int cidx;
        int old;
        int s;
        int f;
        int last;
        bit in_grid;
        pid = int'(it.particle_id);
        case (it.func)
            FUNC_INSERT:
            begin
                in_grid = locate_cell(it.pos_x, it.pos_y, cidx);
                if (!in_grid)
                    return make_res(0, 0, 0, 0, 1'b0, ST_OUTSIDE);
                if (m_fill[cidx] >= CAP)
                    return make_res(cidx, 0, 0, m_fill[cidx], 1'b0, ST_FULL);
                add_to_cell(cidx, pid);
                return make_res(cidx, m_pslot[pid], 0, m_fill[cidx], 1'b0, ST_OK);
            end
            FUNC_MOVE:
            begin
                old = m_pcell[pid];
                s = m_pslot[pid];
                f = m_fill[old];
                in_grid = locate_cell(it.pos_x, it.pos_y, cidx);
                if (!in_grid)
                    return make_res(old, s, 0, f, 1'b0, ST_OUTSIDE);
                if (cidx == old)
                    return make_res(old, s, 0, f, 1'b0, ST_OK);
                if (m_fill[cidx] >= CAP)
                    return make_res(old, s, 0, f, 1'b0, ST_FULL);
                if (s >= f)
                    return make_res(old, s, 0, f, 1'b0, ST_STALE);
                last = int'(m_slots[old*CAP + f - 1]);
                m_slots[old*CAP + s] = last[5:0];
                m_fill[old] = f - 1;
                m_pslot[last] = s;
                add_to_cell(cidx, pid);
                return make_res(cidx, m_pslot[pid], 0, m_fill[cidx], 1'b1, ST_OK);
            end
            FUNC_READ:
            begin
                cidx = int'(it.read_cell);
                s = int'(it.read_slot);
                f = m_fill[cidx];
                if (s >= f)
                    return make_res(cidx, s, 0, f, 1'b0, ST_STALE);
                return make_res(cidx, s, int'(m_slots[cidx*CAP + s]), f, 1'b0, ST_OK);
            end
            default:
                return make_res(0, 0, 0, 0, 1'b0, ST_OK);
        endcase
    endfunction

    // item driver
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item.valid <= 1'b0;
            item.data <= '0;
            send_gap <= 0;
        end
        else if (!item.valid || item.ready)
        begin
            if (item.valid && item.ready)
                expected_bins.push_back(bin_step(item.data));
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                item.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item.data <= pending_items.pop_front();
                item.valid <= 1'b1;
                send_gap <= idle_on ? int'($urandom_range(0, 3)) : 0;
            end
            else
                item.valid <= 1'b0;
        end
    end

    // long receiver hold-off
    int hold_cnt = 0;
    bit hold_done = 1'b0;
    always @(posedge clk)
    begin
        if (!hold_done && results_seen == 200)
        begin
            hold_cnt <= 300;
            hold_done <= 1'b1;
        end
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    // result monitor
    int recv_wait = 0;
    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        int w;
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            recv_wait <= 0;
        end
        else if (result.valid && result.ready)
        begin
            if (expected_bins.size() == 0)
            begin
                $display("%0t: unexpected transaction, actual %p", $time, result.data);
                errors++;
            end
            else
            begin
                exp_r = expected_bins.pop_front();
                if (result.data !== exp_r)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_r, result.data);
                    errors++;
                end
                counts_by_status[exp_r.status]++;
            end
            results_seen++;
            w = idle_on ? int'($urandom_range(0, 3)) : 0;
            recv_wait <= w;
            result.ready <= (w == 0) && (hold_cnt == 0);
        end
        else if (hold_cnt > 0)
            result.ready <= 1'b0;
        else if (recv_wait > 0)
        begin
            recv_wait <= recv_wait - 1;
            result.ready <= 1'b0;
        end
        else
            result.ready <= 1'b1;
    end

    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        cfg.index <= idx;
        cfg.wdata <= val;
        cfg.valid <= 1'b1;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            REG_CELL_SIZE:    m_cell_size = val;
            REG_COLUMN_COUNT: m_cols = val[8:0];
            default:          m_rows = val[8:0];
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || item.valid || expected_bins.size() > 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic set_grid(int cs, int cols, int rows);
        drain();
        write_reg(REG_CELL_SIZE, cs[11:0]);
        write_reg(REG_COLUMN_COUNT, cols[11:0]);
        write_reg(REG_ROW_COUNT, rows[11:0]);
    endtask

    function automatic item_t mk(logic [1:0] fn, int pid, int x, int y, int rc, int rs);
        item_t it;
        it.func = fn;
        it.particle_id = pid[5:0];
        it.pos_x = x[11:0];
        it.pos_y = y[11:0];
        it.read_cell = rc[7:0];
        it.read_slot = rs[3:0];
        return it;
    endfunction

    function automatic item_t rand_item();
        item_t it;
        logic [63:0] rnd;
        int span;
        int pick;
        int pid;
        int tries;
        rnd = {$urandom, $urandom};
        it = item_t'(rnd[$bits(item_t)-1:0]);
        span = ((m_cell_size == 0) ? 1 : int'(m_cell_size)) * int'(m_cols);
        span = (span > 4096 || span < 1) ? 4096 : span;
        if ($urandom_range(0, 9) != 0)
        begin
            it.pos_x = 12'($urandom_range(0, span - 1));
            it.pos_y = 12'($urandom_range(0, span - 1));
        end
        pick = int'($urandom_range(0, 99));
        if (pick < 35)
            it.func = FUNC_INSERT;
        else if (pick < 75)
            it.func = FUNC_MOVE;
        else if (pick < 95)
            it.func = FUNC_READ;
        else
            it.func = 2'd3;
        if (it.func == FUNC_MOVE)
        begin
            pid = -1;
            for (tries = 0; tries < 64 && pid < 0; tries++)
            begin
                it.particle_id = 6'($urandom_range(0, NPART - 1));
                if (m_known[it.particle_id])
                    pid = int'(it.particle_id);
            end
            if (pid < 0)
                it.func = FUNC_INSERT;
        end
        return it;
    endfunction

    task automatic run_random(int n);
        repeat (n)
        begin
            while (pending_items.size() > 2)
                @(posedge clk);
            pending_items.push_back(rand_item());
        end
    endtask

    initial
    begin
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.wdata = '0;
        for (int i = 0; i < NCELL; i++)
            m_fill[i] = 0;
        for (int i = 0; i < NPART; i++)
            m_known[i] = 1'b0;
        for (int i = 0; i < 4; i++)
            counts_by_status[i] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed, reset grid 16x16 of size 16
        pending_items.push_back(mk(FUNC_READ, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(FUNC_INSERT, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(FUNC_INSERT, 63, 4095, 4095, 0, 0));
        pending_items.push_back(mk(FUNC_INSERT, 63, 255, 255, 0, 0));
        pending_items.push_back(mk(FUNC_INSERT, 1, 0, 0, 0, 0));
        pending_items.push_back(mk(FUNC_INSERT, 0, 5, 5, 0, 0));
        pending_items.push_back(mk(FUNC_READ, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(FUNC_READ, 0, 0, 0, 0, 1));
        pending_items.push_back(mk(FUNC_READ, 0, 0, 0, 0, 3));
        pending_items.push_back(mk(FUNC_MOVE, 0, 3, 3, 0, 0));
        pending_items.push_back(mk(FUNC_MOVE, 0, 20, 20, 0, 0));
        pending_items.push_back(mk(FUNC_MOVE, 1, 4095, 0, 0, 0));
        pending_items.push_back(mk(FUNC_MOVE, 1, 255, 255, 0, 0));
        pending_items.push_back(mk(FUNC_READ, 0, 0, 0, 255, 15));
        pending_items.push_back(mk(FUNC_READ, 0, 0, 0, 255, 1));
        pending_items.push_back(mk(2'd3, 63, 4095, 4095, 255, 15));

        set_grid(0, 256, 256);          // zero cell size, index overflow past 256 cells
        pending_items.push_back(mk(FUNC_INSERT, 2, 255, 0, 0, 0));
        pending_items.push_back(mk(FUNC_INSERT, 3, 0, 1, 0, 0));
        pending_items.push_back(mk(FUNC_MOVE, 2, 4095, 0, 0, 0));
        run_random(80);

        set_grid(4095, 1, 1);           // single cell, fills up
        for (int i = 0; i < 18; i++)
            pending_items.push_back(mk(FUNC_INSERT, i + 10, 4094, i * 200, 0, 0));
        run_random(100);                // long receiver hold lands here

        set_grid(4095, 2, 2);
        run_random(120);

        idle_on = 1'b0;
        set_grid(1, 16, 16);
        run_random(60);
        idle_on = 1'b1;

        set_grid(512, 4, 4);
        run_random(120);

        set_grid(16, 16, 16);
        run_random(120);

        drain();
        $display("covered %0d transactions over 7 grid settings incl. zero size and 1x1 grid",
                 results_seen);
        $display("status ok %0d, full %0d, outside %0d, past fill %0d",
                 counts_by_status[0], counts_by_status[1], counts_by_status[2],
                 counts_by_status[3]);
        if (errors == 0 && expected_bins.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end
endmodule
